### sv/fsrp_pkg.sv
// Shared constants and helpers for the scrambled record-to-page mapper.
`timescale 1ns / 1ps
package fsrp_pkg;

	localparam int KEY_BYTES = 8;
	localparam int HASH_W    = 8 * KEY_BYTES;
	localparam int REC_W     = 40;
	localparam int RPP_W     = 16;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 64;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

	// Register indexes (byte address = 8 * index).
	localparam logic REG_RECORD_COUNT     = 1'b0;
	localparam logic REG_RECORDS_PER_PAGE = 1'b1;

	// Multiply by the FNV prime 2^40 + 0x1b3 as a sum of shifted copies.
	function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
		fnv_mul = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

### sv/fsrp_hash.sv
// FNV-1a 64 hash, one byte per pipeline stage.
`timescale 1ns / 1ps
module fsrp_hash (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [fsrp_pkg::REC_W-1:0]  key,
	output logic                        out_valid,
	output logic [fsrp_pkg::HASH_W-1:0] hash
);
	import fsrp_pkg::*;

	logic              v_s   [0:KEY_BYTES];
	logic [HASH_W-1:0] h_s   [0:KEY_BYTES];
	logic [REC_W-1:0]  key_s [0:KEY_BYTES];

	assign v_s[0]   = in_valid;
	assign h_s[0]   = FNV_BASIS;
	assign key_s[0] = key;

	for (genvar k = 0; k < KEY_BYTES; k++) begin : g_stage
		logic [7:0] byte_k;
		if (k < REC_W / 8) begin : g_byte
			assign byte_k = key_s[k][8*k +: 8];
		end else begin : g_zero
			assign byte_k = 8'd0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				h_s[k+1]   <= fnv_mul(h_s[k] ^ {{(HASH_W-8){1'b0}}, byte_k});
				key_s[k+1] <= key_s[k];
			end
		end
	end

	assign out_valid = v_s[KEY_BYTES];
	assign hash      = h_s[KEY_BYTES];

endmodule

### sv/fsrp_mod.sv
// Restoring 64-by-40 remainder, one dividend bit per pipeline stage.
`timescale 1ns / 1ps
module fsrp_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [fsrp_pkg::REC_W-1:0]  modulus,
	input  logic                        in_valid,
	input  logic [fsrp_pkg::HASH_W-1:0] dividend,
	output logic                        out_valid,
	output logic [fsrp_pkg::REC_W-1:0]  remainder
);
	import fsrp_pkg::*;

	logic              v_s [0:HASH_W];
	logic [HASH_W-1:0] d_s [0:HASH_W];
	logic [REC_W-1:0]  r_s [0:HASH_W];

	assign v_s[0] = in_valid;
	assign d_s[0] = dividend;
	assign r_s[0] = '0;

	for (genvar k = 0; k < HASH_W; k++) begin : g_stage
		logic [REC_W:0] trial;
		logic [REC_W:0] diff;
		assign trial = {r_s[k], d_s[k][HASH_W-1]};
		assign diff  = trial - {1'b0, modulus};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1] <= d_s[k] << 1;
				if (trial >= {1'b0, modulus}) begin
					r_s[k+1] <= diff[REC_W-1:0];
				end else begin
					r_s[k+1] <= trial[REC_W-1:0];
				end
			end
		end
	end

	assign out_valid = v_s[HASH_W];
	assign remainder = r_s[HASH_W];

endmodule

### sv/fsrp_div.sv
// Restoring 40-by-16 divider, one quotient bit per stage; carries the dividend along.
`timescale 1ns / 1ps
module fsrp_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [fsrp_pkg::RPP_W-1:0] divisor,
	input  logic                       in_valid,
	input  logic [fsrp_pkg::REC_W-1:0] dividend,
	output logic                       out_valid,
	output logic [fsrp_pkg::REC_W-1:0] dividend_out,
	output logic [fsrp_pkg::REC_W-1:0] quotient
);
	import fsrp_pkg::*;

	logic             v_s [0:REC_W];
	logic [REC_W-1:0] x_s [0:REC_W];
	logic [REC_W-1:0] q_s [0:REC_W];
	logic [RPP_W-1:0] r_s [0:REC_W];

	assign v_s[0] = in_valid;
	assign x_s[0] = dividend;
	assign q_s[0] = dividend;
	assign r_s[0] = '0;

	// q_s shifts dividend bits out at the top and quotient bits in at the bottom.
	for (genvar k = 0; k < REC_W; k++) begin : g_stage
		logic [RPP_W:0] trial;
		logic [RPP_W:0] diff;
		logic           ge;
		assign trial = {r_s[k], q_s[k][REC_W-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1] <= x_s[k];
				q_s[k+1] <= {q_s[k][REC_W-2:0], ge};
				r_s[k+1] <= ge ? diff[RPP_W-1:0] : trial[RPP_W-1:0];
			end
		end
	end

	assign out_valid    = v_s[REC_W];
	assign dividend_out = x_s[REC_W];
	assign quotient     = q_s[REC_W];

endmodule

### sv/fnv_scrambled_record_to_page.sv
// Top level: FNV-1a hash of a record number, reduced to a scrambled index and page.
// The pipeline runs through the hash, remainder and divider stages in that order.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The last divider stage doubles as the output register.
// Reset clears all valid bits and sets record_count and records_per_page to 1.
`timescale 1ns / 1ps
module fnv_scrambled_record_to_page (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fsrp_pkg::ADDR_W-1:0] paddr,
	input  logic [fsrp_pkg::DATA_W-1:0] pwdata,
	output logic [fsrp_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [fsrp_pkg::REC_W-1:0]  record_number,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [fsrp_pkg::REC_W-1:0]  scrambled_index,
	output logic [fsrp_pkg::REC_W-1:0]  page_number
);
	import fsrp_pkg::*;

	logic [REC_W-1:0]  record_count_q;
	logic [RPP_W-1:0]  records_per_page_q;
	logic [REC_W-1:0]  modulus;
	logic [RPP_W-1:0]  divisor;
	logic              en;
	logic              hash_valid;
	logic [HASH_W-1:0] hash;
	logic              idx_valid;
	logic [REC_W-1:0]  idx;
	logic [REC_W-1:0]  quotient;

	// Configuration port: always ready, write on the access phase.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_count_q     <= REC_W'(1);
			records_per_page_q <= RPP_W'(1);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3])
				REG_RECORD_COUNT:     record_count_q     <= pwdata[REC_W-1:0];
				REG_RECORDS_PER_PAGE: records_per_page_q <= pwdata[RPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_RECORD_COUNT:     prdata = DATA_W'(record_count_q);
			REG_RECORDS_PER_PAGE: prdata = DATA_W'(records_per_page_q);
			default:              prdata = '0;
		endcase
	end

	// A zero modulus or divisor behaves as one.
	assign modulus = (record_count_q == '0) ? REC_W'(1) : record_count_q;
	assign divisor = (records_per_page_q == '0) ? RPP_W'(1) : records_per_page_q;

	// Advance every stage together unless a finished result is held at the output.
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	fsrp_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.key       (record_number),
		.out_valid (hash_valid),
		.hash      (hash)
	);

	fsrp_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.modulus   (modulus),
		.in_valid  (hash_valid),
		.dividend  (hash),
		.out_valid (idx_valid),
		.remainder (idx)
	);

	fsrp_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.divisor      (divisor),
		.in_valid     (idx_valid),
		.dividend     (idx),
		.out_valid    (out_valid),
		.dividend_out (scrambled_index),
		.quotient     (quotient)
	);

	// Page numbers start at one.
	assign page_number = quotient + REC_W'(1);

endmodule

### bench/fnv_scrambled_record_to_page_test.sv
// Self-checking bench for the scrambled record-to-page mapper: table-driven and random requests.
`timescale 1ns / 1ps
module fnv_scrambled_record_to_page_test;
	import fsrp_pkg::*;

	localparam int LATENCY     = 112;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 450;

	// Register byte addresses: registers sit 8 bytes apart because record_count is 40 bits.
	localparam logic [ADDR_W-1:0] ADDR_RECORD_COUNT     = ADDR_W'(8 * REG_RECORD_COUNT);
	localparam logic [ADDR_W-1:0] ADDR_RECORDS_PER_PAGE = ADDR_W'(8 * REG_RECORDS_PER_PAGE);

	typedef struct packed {
		logic [REC_W-1:0] index;
		logic [REC_W-1:0] page;
	} page_map_t;

	// One row of the directed table; a row with has_known set carries its result by hand.
	typedef struct {
		logic [REC_W-1:0] record;
		bit               has_known;
		page_map_t        known;
	} record_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_ready;
	logic [REC_W-1:0]  record_number;
	logic              out_valid;
	logic              out_ready;
	logic [REC_W-1:0]  scrambled_index;
	logic [REC_W-1:0]  page_number;

	// Predictor's own copy of the two registers.
	logic [REC_W-1:0] model_record_count;
	logic [RPP_W-1:0] model_records_per_page;

	page_map_t   pending_pages[$];
	int          mismatch_count;
	int          cycle_count;
	bit          out_stall_enable;
	record_row_t record_table[$];

	fnv_scrambled_record_to_page i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.record_number   (record_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.scrambled_index (scrambled_index),
		.page_number     (page_number)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Hash eight little-endian bytes with FNV-1a 64, reduce, then divide into a page.
	function automatic page_map_t map_record(input logic [REC_W-1:0] rec);
		logic [63:0] hash;
		logic [63:0] modulus;
		logic [63:0] divisor;
		logic [63:0] key;
		page_map_t   res;
		hash = 64'hcbf29ce484222325;
		key = {24'd0, rec};
		for (int b = 0; b < 8; b++) begin
			hash = hash ^ {56'd0, key[8*b +: 8]};
			hash = hash * 64'h00000100000001b3;
		end
		// A zero register behaves as one.
		modulus = (model_record_count == '0) ? 64'd1 : {24'd0, model_record_count};
		divisor = (model_records_per_page == '0) ? 64'd1 : {48'd0, model_records_per_page};
		res.index = REC_W'(hash % modulus);
		res.page = REC_W'(res.index / divisor + 64'd1);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [REC_W-1:0] got,
			input logic [REC_W-1:0] want);
		$display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Write one register through the APB port: setup cycle, then access cycle.
	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// Mirror the register, dropping bits above its width.
		if (addr == ADDR_RECORD_COUNT) begin
			model_record_count = data[REC_W-1:0];
		end else if (addr == ADDR_RECORDS_PER_PAGE) begin
			model_records_per_page = data[RPP_W-1:0];
		end
	endtask

	// Mostly short gaps, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(0, 19) == 0) begin
			return $urandom_range(10, 40);
		end
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	// Hold the request until accepted, then record its expected page.
	// Drop valid only across a gap; back-to-back requests keep it high.
	task automatic send_record(input logic [REC_W-1:0] rec, input bit has_known,
			input page_map_t known, input bit allow_gaps);
		int gap;
		gap = allow_gaps ? gap_length() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		record_number <= rec;
		do @(posedge clk); while (!in_ready);
		pending_pages.push_back(has_known ? known : map_record(rec));
	endtask

	// Drain every pending result, then let the pipeline settle before a register write.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (pending_pages.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic [REC_W-1:0] random_record();
		case ($urandom_range(0, 4))
			0: return REC_W'($urandom_range(0, 255));
			1: return {REC_W{1'b1}} - REC_W'($urandom_range(0, 255));
			default: return {8'($urandom), 32'($urandom)};
		endcase
	endfunction

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		page_map_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pages.size() == 0) begin
				report_mismatch("unexpected scrambled_index", scrambled_index, '0);
			end else begin
				want = pending_pages.pop_front();
				if (scrambled_index !== want.index) begin
					report_mismatch("scrambled_index", scrambled_index, want.index);
				end
				if (page_number !== want.page) begin
					report_mismatch("page_number", page_number, want.page);
				end
			end
		end
	end

	// Randomly stall the result side, with calm stretches.
	always @(posedge clk) begin
		if (!out_stall_enable) begin
			out_ready <= 1'b1;
		end else if ($urandom_range(0, 49) == 0) begin
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready <= ~out_ready;
		end
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		record_row_t row;
		page_map_t   known;
		logic [REC_W-1:0] rc_set[$];
		logic [RPP_W-1:0] rpp_set[$];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		record_number = '0;
		out_ready = 1'b1;
		out_stall_enable = 1'b0;
		mismatch_count = 0;
		cycle_count = 0;
		model_record_count = 1;
		model_records_per_page = 1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset both registers are one: index 0, page 1 for any record.
		known.index = '0;
		known.page = 40'd1;
		record_table.push_back('{40'd0, 1'b1, known});
		record_table.push_back('{{REC_W{1'b1}}, 1'b1, known});
		record_table.push_back('{40'h55_5555_5555, 1'b1, known});
		foreach (record_table[i]) begin
			row = record_table[i];
			send_record(row.record, row.has_known, row.known, 1'b0);
		end
		drain_pipeline();

		// Widest modulus and divider, with junk above the register widths.
		write_reg(ADDR_RECORD_COUNT, {24'hFFFFFF, {REC_W{1'b1}}});
		write_reg(ADDR_RECORDS_PER_PAGE, {48'hFFFF_FFFF_FFFF, 16'hFFFF});
		record_table.delete();
		record_table.push_back('{40'd0, 1'b0, known});
		record_table.push_back('{40'd1, 1'b0, known});
		record_table.push_back('{{REC_W{1'b1}}, 1'b0, known});
		record_table.push_back('{40'h80_0000_0000, 1'b0, known});
		record_table.push_back('{40'hAA_AAAA_AAAA, 1'b0, known});
		record_table.push_back('{40'h55_5555_5555, 1'b0, known});
		record_table.push_back('{40'h00_0000_00FF, 1'b0, known});
		foreach (record_table[i]) begin
			row = record_table[i];
			send_record(row.record, row.has_known, row.known, 1'b0);
		end
		drain_pipeline();

		// Zero registers act as one.
		write_reg(ADDR_RECORD_COUNT, 64'd0);
		write_reg(ADDR_RECORDS_PER_PAGE, 64'd0);
		send_record(40'h12_3456_789A, 1'b1, known, 1'b0);
		drain_pipeline();

		write_reg(ADDR_RECORD_COUNT, 64'd1000);
		write_reg(ADDR_RECORDS_PER_PAGE, 64'd0);
		record_table.delete();
		record_table.push_back('{40'd7, 1'b0, known});
		record_table.push_back('{{REC_W{1'b1}}, 1'b0, known});
		foreach (record_table[i]) begin
			row = record_table[i];
			send_record(row.record, row.has_known, row.known, 1'b0);
		end
		drain_pipeline();

		// Random phases, each under its own register setting.
		rc_set = '{40'd1, {REC_W{1'b1}}, 40'd1000003, 40'h01_0000_0000, 40'd0};
		rpp_set = '{16'd1, 16'hFFFF, 16'd64, 16'd7, 16'd0};
		out_stall_enable = 1'b1;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase < 5) begin
				write_reg(ADDR_RECORD_COUNT, {24'($urandom), rc_set[phase]});
				write_reg(ADDR_RECORDS_PER_PAGE, {48'd0, rpp_set[phase]});
			end else begin
				write_reg(ADDR_RECORD_COUNT, {24'd0, 8'($urandom), 32'($urandom)});
				write_reg(ADDR_RECORDS_PER_PAGE, 64'($urandom_range(1, 65535)));
			end
			for (int n = 0; n < RAND_ITEMS / 6; n++) begin
				// Every third block of twenty requests runs back to back to fill the pipeline.
				send_record(random_record(), 1'b0, known, (n / 20) % 3 != 0);
			end
			drain_pipeline();
		end

		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
